@@ design/trdt_pkg.sv @@
`timescale 1ns / 1ps
// Package for the triangle rasterizer with depth test.
// Shared types, opcodes, state codes and constants. No dependencies.
package trdt_pkg;

	localparam int DEF_MAX_COLUMNS = 128;
	localparam int DEF_MAX_ROWS    = 64;

	localparam int CRD_W  = 12;  // coordinate width
	localparam int DIF_W  = 13;  // coordinate difference
	localparam int EDG_W  = 27;  // edge function / area
	localparam int Z_W    = 16;  // Q8.8 depth
	localparam int PRD_W  = EDG_W + Z_W;
	localparam int ACC_W  = 46;  // sum of three products
	localparam int QUO_W  = ACC_W + 1;
	localparam int CNT_W  = 14;

	localparam logic [7:0]     BLANK      = 8'h20;
	localparam logic [Z_W-1:0] DEPTH_FAR  = 16'h7fff;
	localparam logic [CNT_W-1:0] COUNT_MAX = 14'h3fff;

	localparam logic [7:0] WIDTH_RESET  = 8'd90;
	localparam logic [6:0] HEIGHT_RESET = 7'd40;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} trdt_op_t;

	// multiply steps of the sequencer
	localparam logic [3:0] STEP_AREA_END = 4'd1;
	localparam logic [3:0] STEP_PIX0     = 4'd2;
	localparam logic [3:0] STEP_E0_END   = 4'd3;
	localparam logic [3:0] STEP_E1_END   = 4'd5;
	localparam logic [3:0] STEP_EDGE_END = 4'd7;
	localparam logic [3:0] STEP_Z0       = 4'd8;
	localparam logic [3:0] STEP_Z_END    = 4'd10;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_MUL,
		ST_ACC,
		ST_TEST,
		ST_DIV,
		ST_DIVW,
		ST_CMP,
		ST_NEXT,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FIN
	} trdt_state_t;

	typedef struct packed {
		logic [7:0]  width;
		logic [6:0]  height;
	} trdt_cfg_t;

endpackage

@@ design/trdt_if.sv @@
`timescale 1ns / 1ps
// Command and response channel interfaces of the rasterizer.
// Depends on trdt_pkg.
interface trdt_cmd_if
	import trdt_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic signed [CRD_W-1:0]  x0;
	logic signed [CRD_W-1:0]  y0;
	logic signed [CRD_W-1:0]  x1;
	logic signed [CRD_W-1:0]  y1;
	logic signed [CRD_W-1:0]  x2;
	logic signed [CRD_W-1:0]  y2;
	logic signed [Z_W-1:0]    z0;
	logic signed [Z_W-1:0]    z1;
	logic signed [Z_W-1:0]    z2;
	logic [7:0]               glyph;

	modport source (output valid, opcode, x0, y0, x1, y1, x2, y2, z0, z1, z2, glyph,
		input ready);
	modport sink (input valid, opcode, x0, y0, x1, y1, x2, y2, z0, z1, z2, glyph,
		output ready);
endinterface

interface trdt_rsp_if
	import trdt_pkg::*;
	();
	logic                   valid;
	logic                   ready;
	logic [7:0]             cell_char;
	logic signed [Z_W-1:0]  cell_depth;
	logic [CNT_W-1:0]       pixels_written;

	modport source (output valid, cell_char, cell_depth, pixels_written, input ready);
	modport sink (input valid, cell_char, cell_depth, pixels_written, output ready);
endinterface

@@ design/trdt_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on trdt_pkg.
module trdt_mul
	import trdt_pkg::*;
(
	input  logic                     clk,
	input  logic signed [EDG_W-1:0]  a,
	input  logic signed [Z_W-1:0]    b,
	output logic signed [PRD_W-1:0]  prod
);

	logic signed [PRD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PRD_W'(a) * PRD_W'(b);
	end

	assign prod = prod_q;

endmodule

@@ design/trdt_div.sv @@
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on trdt_pkg.
module trdt_div
	import trdt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ACC_W-1:0]  num,
	input  logic signed [EDG_W-1:0]  den,
	output logic                     busy,
	output logic                     done,
	output logic signed [QUO_W-1:0]  quot
);

	localparam int CW = $clog2(ACC_W + 1);

	logic              busy_q, done_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [ACC_W-1:0]  quo_q;
	logic [EDG_W-1:0]  rem_q, dabs_q;
	logic [EDG_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, quo_q[ACC_W-1]};
	assign ge    = trial >= {1'b0, dabs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[ACC_W-1] ^ den[EDG_W-1];
			quo_q  <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
			dabs_q <= den[EDG_W-1] ? EDG_W'(-den) : EDG_W'(den);
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? EDG_W'(trial - {1'b0, dabs_q}) : trial[EDG_W-1:0];
			quo_q <= {quo_q[ACC_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	property p_start_idle;
		@(posedge clk) disable iff (!arst_n) start |-> !busy_q;
	endproperty
	a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q);
	endproperty
	a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

	property p_start_runs;
		@(posedge clk) disable iff (!arst_n) start |=> busy_q && !done_q;
	endproperty
	a_start_runs: assert property (p_start_runs) else $error("divider did not start");

endmodule

@@ design/trdt_core.sv @@
`timescale 1ns / 1ps
// Sequencer, frame/depth memory and datapath of the rasterizer.
// Depends on trdt_pkg, trdt_if, trdt_mul and trdt_div.
module trdt_core
	import trdt_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
)(
	input  logic       clk,
	input  logic       arst_n,
	input  trdt_cfg_t  cfg,
	trdt_cmd_if.sink   cmd,
	trdt_rsp_if.source rsp
);

	localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int MW    = 8 + Z_W;

	trdt_state_t state_q, state_d;

	logic [3:0]               step_q;
	logic [1:0]               op_q;
	logic signed [CRD_W-1:0]  ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [Z_W-1:0]    za_q, zb_q, zc_q;
	logic [7:0]               glyph_q;
	logic signed [CRD_W-1:0]  px_q, py_q;
	logic signed [ACC_W-1:0]  acc_q, acc_nxt;
	logic signed [EDG_W-1:0]  area_q;
	logic signed [EDG_W-1:0]  e_q [3];
	logic [CNT_W-1:0]         cnt_q;
	logic [7:0]               res_char_q;
	logic signed [Z_W-1:0]    res_depth_q;
	logic [AW-1:0]            clr_q;
	logic                     out_valid_q;
	logic [7:0]               out_char_q;
	logic signed [Z_W-1:0]    out_depth_q;
	logic [CNT_W-1:0]         out_cnt_q;

	logic [MW-1:0]            mem [CELLS];
	logic [MW-1:0]            mem_rd_q;
	logic                     mem_we;
	logic [AW-1:0]            mem_addr;
	logic [MW-1:0]            mem_wdata;

	logic signed [CRD_W-1:0]  wm1, hm1, lx, hx, ly, hy, mnx, mxx, mny, mxy;
	logic                     bbox_empty, last_pix, covered, rd_in, nearer, slot_free;
	logic signed [EDG_W-1:0]  mul_a;
	logic signed [Z_W-1:0]    mul_b;
	logic signed [PRD_W-1:0]  prod;
	logic                     op_start, op_neg;
	logic                     div_start, div_busy, div_done;
	logic signed [QUO_W-1:0]  quot;
	logic signed [Z_W-1:0]    z_clamp;
	logic [AW-1:0]            pix_addr, rd_addr;

	function automatic logic signed [DIF_W-1:0] dif(input logic signed [CRD_W-1:0] a,
		input logic signed [CRD_W-1:0] b);
		return DIF_W'(a) - DIF_W'(b);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
		input logic signed [CRD_W-1:0] y);
		return AW'(32'(y[CRD_W-2:0]) * 32'(MAX_COLUMNS) + 32'(x[CRD_W-2:0]));
	endfunction

	// screen limits, register values clamped to 1..MAX
	always_comb begin
		if (cfg.width == '0)
			wm1 = '0;
		else if (CRD_W'(cfg.width) > CRD_W'(MAX_COLUMNS))
			wm1 = CRD_W'(MAX_COLUMNS - 1);
		else
			wm1 = CRD_W'(cfg.width) - 1'b1;
		if (cfg.height == '0)
			hm1 = '0;
		else if (CRD_W'(cfg.height) > CRD_W'(MAX_ROWS))
			hm1 = CRD_W'(MAX_ROWS - 1);
		else
			hm1 = CRD_W'(cfg.height) - 1'b1;
	end

	// clipped bounding box
	always_comb begin
		mnx = (ax_q < bx_q) ? ax_q : bx_q;
		mnx = (mnx < cx_q) ? mnx : cx_q;
		mxx = (ax_q > bx_q) ? ax_q : bx_q;
		mxx = (mxx > cx_q) ? mxx : cx_q;
		mny = (ay_q < by_q) ? ay_q : by_q;
		mny = (mny < cy_q) ? mny : cy_q;
		mxy = (ay_q > by_q) ? ay_q : by_q;
		mxy = (mxy > cy_q) ? mxy : cy_q;
		lx  = mnx[CRD_W-1] ? '0 : mnx;
		ly  = mny[CRD_W-1] ? '0 : mny;
		hx  = (mxx > wm1) ? wm1 : mxx;
		hy  = (mxy > hm1) ? hm1 : mxy;
	end

	assign bbox_empty = (lx > hx) || (ly > hy);
	assign last_pix   = (px_q == hx) && (py_q == hy);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			4'd0: begin mul_a = EDG_W'(dif(cx_q, ax_q)); mul_b = Z_W'(dif(by_q, ay_q)); end
			4'd1: begin mul_a = EDG_W'(dif(cy_q, ay_q)); mul_b = Z_W'(dif(bx_q, ax_q)); end
			4'd2: begin mul_a = EDG_W'(dif(px_q, bx_q)); mul_b = Z_W'(dif(cy_q, by_q)); end
			4'd3: begin mul_a = EDG_W'(dif(py_q, by_q)); mul_b = Z_W'(dif(cx_q, bx_q)); end
			4'd4: begin mul_a = EDG_W'(dif(px_q, cx_q)); mul_b = Z_W'(dif(ay_q, cy_q)); end
			4'd5: begin mul_a = EDG_W'(dif(py_q, cy_q)); mul_b = Z_W'(dif(ax_q, cx_q)); end
			4'd6: begin mul_a = EDG_W'(dif(px_q, ax_q)); mul_b = Z_W'(dif(by_q, ay_q)); end
			4'd7: begin mul_a = EDG_W'(dif(py_q, ay_q)); mul_b = Z_W'(dif(bx_q, ax_q)); end
			4'd8: begin mul_a = e_q[0]; mul_b = za_q; end
			4'd9: begin mul_a = e_q[1]; mul_b = zb_q; end
			4'd10: begin mul_a = e_q[2]; mul_b = zc_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	trdt_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign op_start = !step_q[0] && (step_q <= STEP_Z0);
	assign op_neg   = step_q[0] && (step_q <= STEP_EDGE_END);
	assign acc_nxt  = (op_start ? '0 : acc_q) + (op_neg ? -ACC_W'(prod) : ACC_W'(prod));

	always_comb begin
		if (!area_q[EDG_W-1])
			covered = !e_q[0][EDG_W-1] && !e_q[1][EDG_W-1] && !e_q[2][EDG_W-1];
		else
			covered = (e_q[0][EDG_W-1] || e_q[0] == '0) && (e_q[1][EDG_W-1] || e_q[1] == '0)
				&& (e_q[2][EDG_W-1] || e_q[2] == '0);
	end

	trdt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (area_q),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		if (quot > QUO_W'(32767))
			z_clamp = 16'sh7fff;
		else if (quot < -QUO_W'(32768))
			z_clamp = -16'sh8000;
		else
			z_clamp = quot[Z_W-1:0];
	end

	assign nearer    = z_clamp < $signed(mem_rd_q[Z_W-1:0]);
	assign rd_in     = !ax_q[CRD_W-1] && (ax_q <= wm1) && !ay_q[CRD_W-1] && (ay_q <= hm1);
	assign pix_addr  = cell_addr(px_q, py_q);
	assign rd_addr   = cell_addr(ax_q, ay_q);
	assign slot_free = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:  if (clr_q == AW'(CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (cmd.valid) begin
					case (trdt_op_t'(cmd.opcode))
						OP_CLEAR: state_d = ST_CLEAR;
						OP_DRAW:  state_d = ST_MUL;
						OP_READ:  state_d = ST_RD_ADDR;
						default:  state_d = ST_FIN;
					endcase
				end
			end
			ST_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = ST_FIN;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC: begin
				if (step_q == STEP_AREA_END)
					state_d = (acc_nxt == '0 || bbox_empty) ? ST_FIN : ST_MUL;
				else if (step_q == STEP_EDGE_END)
					state_d = ST_TEST;
				else if (step_q == STEP_Z_END)
					state_d = ST_DIV;
				else
					state_d = ST_MUL;
			end
			ST_TEST:    state_d = covered ? ST_MUL : ST_NEXT;
			ST_DIV:     state_d = ST_DIVW;
			ST_DIVW:    if (div_done) state_d = ST_CMP;
			ST_CMP:     state_d = ST_NEXT;
			ST_NEXT:    state_d = last_pix ? ST_FIN : ST_MUL;
			ST_RD_ADDR: state_d = rd_in ? ST_RD_DATA : ST_FIN;
			ST_RD_DATA: state_d = ST_FIN;
			ST_FIN:     if (slot_free) state_d = ST_IDLE;
			default:    state_d = ST_INIT;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd.ready = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = pix_addr;
		mem_wdata = {glyph_q, z_clamp};
		div_start = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = {BLANK, DEPTH_FAR};
			end
			ST_IDLE:    cmd.ready = 1'b1;
			ST_DIV:     div_start = 1'b1;
			ST_CMP:     mem_we = nearer;
			ST_RD_ADDR: mem_addr = rd_addr;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		mem_rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && slot_free)
				out_valid_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					clr_q  <= '0;
					step_q <= '0;
					cnt_q  <= '0;
				end
				ST_ACC: step_q <= step_q + 1'b1;
				ST_TEST: step_q <= STEP_Z0;
				ST_CMP: if (nearer && cnt_q != COUNT_MAX) cnt_q <= cnt_q + 1'b1;
				ST_NEXT: step_q <= STEP_PIX0;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q        <= cmd.opcode;
				ax_q        <= cmd.x0;
				ay_q        <= cmd.y0;
				bx_q        <= cmd.x1;
				by_q        <= cmd.y1;
				cx_q        <= cmd.x2;
				cy_q        <= cmd.y2;
				za_q        <= cmd.z0;
				zb_q        <= cmd.z1;
				zc_q        <= cmd.z2;
				glyph_q     <= cmd.glyph;
				res_char_q  <= '0;
				res_depth_q <= '0;
			end
			ST_ACC: begin
				acc_q <= acc_nxt;
				if (step_q == STEP_AREA_END) begin
					area_q <= acc_nxt[EDG_W-1:0];
					px_q   <= lx;
					py_q   <= ly;
				end
				if (step_q == STEP_E0_END) e_q[0] <= acc_nxt[EDG_W-1:0];
				if (step_q == STEP_E1_END) e_q[1] <= acc_nxt[EDG_W-1:0];
				if (step_q == STEP_EDGE_END) e_q[2] <= acc_nxt[EDG_W-1:0];
			end
			ST_NEXT: begin
				if (px_q == hx) begin
					px_q <= lx;
					py_q <= py_q + 1'b1;
				end else begin
					px_q <= px_q + 1'b1;
				end
			end
			ST_RD_ADDR: begin
				res_char_q  <= BLANK;
				res_depth_q <= DEPTH_FAR;
			end
			ST_RD_DATA: begin
				res_char_q  <= mem_rd_q[MW-1:Z_W];
				res_depth_q <= mem_rd_q[Z_W-1:0];
			end
			ST_FIN: begin
				if (slot_free) begin
					out_char_q  <= res_char_q;
					out_depth_q <= res_depth_q;
					out_cnt_q   <= (op_q == OP_DRAW) ? cnt_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.cell_char      = out_char_q;
	assign rsp.cell_depth     = out_depth_q;
	assign rsp.pixels_written = out_cnt_q;

	property p_cmp_in_box;
		@(posedge clk) disable iff (!arst_n)
			state_q == ST_CMP |-> px_q >= lx && px_q <= hx && py_q >= ly && py_q <= hy;
	endproperty
	a_cmp_in_box: assert property (p_cmp_in_box) else $error("pixel outside box");

	property p_write_counts;
		@(posedge clk) disable iff (!arst_n)
			state_q == ST_CMP && nearer |=> cnt_q == $past(cnt_q) + 1'b1 || cnt_q == COUNT_MAX;
	endproperty
	a_write_counts: assert property (p_write_counts) else $error("write not counted");

	property p_cmp_after_div;
		@(posedge clk) disable iff (!arst_n)
			state_q == ST_CMP |-> $past(div_done) && !div_busy;
	endproperty
	a_cmp_after_div: assert property (p_cmp_after_div) else $error("compare before quotient");

endmodule

@@ design/triangle_rasterizer_depth_test.sv @@
`timescale 1ns / 1ps
// Top level of the triangle rasterizer with depth test: APB registers and core.
// Depends on trdt_pkg, trdt_if and trdt_core.
//
// Usage:
//   cmd channel takes one transaction per operation: clear, draw, read or no-op.
//   rsp channel returns exactly one transaction per command, in order.
//   APB registers: screen_width at 0x0, screen_height at 0x4, write only when idle.
// Operation (one command at a time, cmd.ready high only when idle):
//   clear: sweeps the whole store, one memory write per cycle.
//   read:  registers the cell address, then reads the cell if it is on screen.
//   draw:  computes the area, then for each pixel of the clipped bounding box the
//          edge functions and the step to the next pixel, and for a covered pixel
//          also the depth sum, divide and compare; the shared multiplier and the
//          one-bit-per-cycle divider do this work.
// Reset: after arst_n is released the block sweeps the whole store to blank
//   and far depth with cmd.ready low.
// Stall: the result sits in an output register; when rsp.ready is low and a
//   further result is finished, the block holds it and waits.
module triangle_rasterizer_depth_test
	import trdt_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	trdt_cmd_if.sink    cmd,
	trdt_rsp_if.source  rsp
);

	trdt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2])
				cfg_q.height <= pwdata[6:0];
			else
				cfg_q.width <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {25'd0, cfg_q.height} : {24'd0, cfg_q.width};

	trdt_core #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

@@ test/triangle_rasterizer_depth_test_test.sv @@
`timescale 1ns / 1ps
// Testbench for triangle_rasterizer_depth_test: clear, draw, read and no-op commands
// checked against an internal frame/depth predictor. Depends on trdt_pkg, trdt_if.
module triangle_rasterizer_depth_test_test;
	import trdt_pkg::*;

	localparam int COLS  = DEF_MAX_COLUMNS;
	localparam int ROWS  = DEF_MAX_ROWS;
	localparam int CELLS = COLS * ROWS;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		trdt_op_t                op;
		logic signed [CRD_W-1:0] x0, y0, x1, y1, x2, y2;
		logic signed [Z_W-1:0]   z0, z1, z2;
		logic [7:0]              glyph;
	} raster_cmd_t;

	typedef struct {
		logic [7:0]            cell_char;
		logic signed [Z_W-1:0] cell_depth;
		logic [CNT_W-1:0]      pixels_written;
	} cell_result_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	trdt_cmd_if cmd_ch ();
	trdt_rsp_if rsp_ch ();

	triangle_rasterizer_depth_test dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd(cmd_ch.sink), .rsp(rsp_ch.source)
	);

	raster_cmd_t  pending_cmds[$];
	cell_result_t expected_cells[$];
	raster_cmd_t  cur_cmd;

	logic [7:0]            frame_chars [CELLS];
	logic signed [Z_W-1:0] frame_depths[CELLS];
	logic [7:0] width_reg;
	logic [6:0] height_reg;

	int  errors;
	int  src_gap, sink_gap, long_hold_left;
	bit  bursts_on, long_hold_req;
	longint cycle_count;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
		longint px, longint py);
		return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
	endfunction

	function automatic longint min3(longint a, longint b, longint c);
		longint m;
		m = a < b ? a : b;
		return m < c ? m : c;
	endfunction

	function automatic longint max3(longint a, longint b, longint c);
		longint m;
		m = a > b ? a : b;
		return m > c ? m : c;
	endfunction

	function automatic longint used_size(longint v, longint lim);
		if (v < 1) v = 1;
		if (v > lim) v = lim;
		return v;
	endfunction

	function automatic void blank_frame();
		for (int i = 0; i < CELLS; i++) begin
			frame_chars[i] = BLANK;
			frame_depths[i] = DEPTH_FAR;
		end
	endfunction

	function automatic cell_result_t predict_cell(raster_cmd_t c);
		cell_result_t r;
		longint w, h, area, lx, hx, ly, hy, e0, e1, e2, z;
		longint ax, ay, bx, by, cx, cy;
		int idx, cnt;
		bit hit;
		r.cell_char = 0;
		r.cell_depth = 0;
		r.pixels_written = 0;
		w = used_size(width_reg, COLS);
		h = used_size(height_reg, ROWS);
		ax = c.x0; ay = c.y0; bx = c.x1; by = c.y1; cx = c.x2; cy = c.y2;
		case (c.op)
			OP_CLEAR: blank_frame();
			OP_DRAW: begin
				cnt = 0;
				area = edge_val(ax, ay, bx, by, cx, cy);
				if (area != 0) begin
					lx = min3(ax, bx, cx); if (lx < 0) lx = 0;
					hx = max3(ax, bx, cx); if (hx > w - 1) hx = w - 1;
					ly = min3(ay, by, cy); if (ly < 0) ly = 0;
					hy = max3(ay, by, cy); if (hy > h - 1) hy = h - 1;
					for (longint py = ly; py <= hy; py++) begin
						for (longint px = lx; px <= hx; px++) begin
							e0 = edge_val(bx, by, cx, cy, px, py);
							e1 = edge_val(cx, cy, ax, ay, px, py);
							e2 = edge_val(ax, ay, bx, by, px, py);
							if (area > 0) hit = e0 >= 0 && e1 >= 0 && e2 >= 0;
							else hit = e0 <= 0 && e1 <= 0 && e2 <= 0;
							if (hit) begin
								z = (e0 * longint'(c.z0) + e1 * longint'(c.z1)
									+ e2 * longint'(c.z2)) / area;
								if (z > 32767) z = 32767;
								if (z < -32768) z = -32768;
								idx = int'(py) * COLS + int'(px);
								if (z < longint'(frame_depths[idx])) begin
									frame_depths[idx] = z[15:0];
									frame_chars[idx] = c.glyph;
									if (cnt < 16383) cnt++;
								end
							end
						end
					end
				end
				r.pixels_written = cnt[CNT_W-1:0];
			end
			OP_READ: begin
				r.cell_char = BLANK;
				r.cell_depth = DEPTH_FAR;
				if (ax >= 0 && ax < w && ay >= 0 && ay < h) begin
					idx = int'(ay) * COLS + int'(ax);
					r.cell_char = frame_chars[idx];
					r.cell_depth = frame_depths[idx];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready)
			expected_cells.push_back(predict_cell(cur_cmd));
		if (!cmd_ch.valid || cmd_ch.ready) begin
			if (src_gap > 0) begin
				src_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				cur_cmd = pending_cmds.pop_front();
				cmd_ch.valid  <= 1'b1;
				cmd_ch.opcode <= cur_cmd.op;
				cmd_ch.x0 <= cur_cmd.x0; cmd_ch.y0 <= cur_cmd.y0;
				cmd_ch.x1 <= cur_cmd.x1; cmd_ch.y1 <= cur_cmd.y1;
				cmd_ch.x2 <= cur_cmd.x2; cmd_ch.y2 <= cur_cmd.y2;
				cmd_ch.z0 <= cur_cmd.z0; cmd_ch.z1 <= cur_cmd.z1;
				cmd_ch.z2 <= cur_cmd.z2;
				cmd_ch.glyph <= cur_cmd.glyph;
				if (bursts_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 15);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req <= 1'b0;
			long_hold_left <= 400;
		end else if (long_hold_left > 0) begin
			long_hold_left <= long_hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		cell_result_t w;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_cells.size() == 0) begin
				$display("unexpected response transaction");
				errors++;
			end else begin
				w = expected_cells.pop_front();
				if (rsp_ch.cell_char !== w.cell_char)
					report("cell_char", rsp_ch.cell_char, w.cell_char);
				if (rsp_ch.cell_depth !== w.cell_depth)
					report("cell_depth", rsp_ch.cell_depth, w.cell_depth);
				if (rsp_ch.pixels_written !== w.pixels_written)
					report("pixels_written", rsp_ch.pixels_written, w.pixels_written);
			end
		end
		if (long_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (bursts_on && $urandom_range(0, 5) == 0)
				sink_gap = $urandom_range(1, 15);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("triangle_rasterizer_depth_test_test failed");
			$finish;
		end
	end

	function automatic void push_cmd(trdt_op_t op, int x0, int y0, int x1, int y1,
		int x2, int y2, int z0, int z1, int z2, int glyph);
		raster_cmd_t c;
		c.op = op;
		c.x0 = x0[11:0]; c.y0 = y0[11:0];
		c.x1 = x1[11:0]; c.y1 = y1[11:0];
		c.x2 = x2[11:0]; c.y2 = y2[11:0];
		c.z0 = z0[15:0]; c.z1 = z1[15:0]; c.z2 = z2[15:0];
		c.glyph = glyph[7:0];
		pending_cmds.push_back(c);
	endfunction

	function automatic void push_read(int x, int y);
		push_cmd(OP_READ, x, y, 0, 0, 0, 0, 0, 0, 0, 0);
	endfunction

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_cells.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(int index, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(index * 4); pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (index == 0) width_reg = data[7:0];
		else height_reg = data[6:0];
	endtask

	function automatic int rnd_coord(int lo, int hi);
		if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 4095)) - 2048;
		return int'($urandom_range(0, hi - lo)) + lo;
	endfunction

	function automatic void push_random(int w, int h);
		int k;
		k = $urandom_range(0, 99);
		if (k < 62)
			push_cmd(OP_DRAW, rnd_coord(-3, w + 2), rnd_coord(-3, h + 2),
				rnd_coord(-3, w + 2), rnd_coord(-3, h + 2),
				rnd_coord(-3, w + 2), rnd_coord(-3, h + 2),
				$urandom, $urandom, $urandom, $urandom_range(0, 255));
		else if (k < 94)
			push_read(rnd_coord(-2, w + 1), rnd_coord(-2, h + 1));
		else if (k < 97)
			push_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
		else
			push_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	initial begin
		errors = 0; src_gap = 0; sink_gap = 0; long_hold_left = 0;
		bursts_on = 1; long_hold_req = 0; cycle_count = 0;
		width_reg = WIDTH_RESET; height_reg = HEIGHT_RESET;
		blank_frame();
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		cmd_ch.valid = 0; cmd_ch.opcode = 0; cmd_ch.glyph = 0;
		cmd_ch.x0 = 0; cmd_ch.y0 = 0; cmd_ch.x1 = 0; cmd_ch.y1 = 0;
		cmd_ch.x2 = 0; cmd_ch.y2 = 0; cmd_ch.z0 = 0; cmd_ch.z1 = 0; cmd_ch.z2 = 0;
		rsp_ch.ready = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset size 90x40
		push_read(0, 0);
		push_cmd(OP_DRAW, 0, 0, 5, 0, 0, 5, 256, 256, 256, 8'h41);
		push_cmd(OP_DRAW, 0, 0, 0, 5, 5, 0, -32768, -32768, -32768, 8'h42);
		push_cmd(OP_DRAW, 0, 0, 0, 5, 5, 0, -32768, -32768, -32768, 8'h43);
		push_cmd(OP_DRAW, 1, 1, 3, 3, 6, 6, 0, 0, 0, 8'h44);
		push_cmd(OP_DRAW, 80, 30, 95, 36, 84, 45, 32767, -32768, 1000, 255);
		push_read(1, 1);
		push_read(85, 36);
		push_read(89, 39);
		push_read(90, 0);
		push_read(-1, 0);
		push_read(2047, 2047);
		push_read(-2048, -2048);
		push_cmd(OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1, 255);
		push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		push_read(1, 1);
		wait_idle();

		// out-of-range sizes act as 1x1
		write_reg(0, 32'hffff_ff00);
		write_reg(1, 32'hffff_ff80);
		push_cmd(OP_DRAW, -2048, -2048, 2047, -2048, -2048, 2047, 32767, 32767, 32767, 1);
		push_cmd(OP_DRAW, 2047, 2047, -2048, 2047, 2047, -2048, -32768, 0, 7, 2);
		push_read(0, 0);
		push_read(1, 0);
		push_read(0, 1);
		wait_idle();

		// sizes above the maximum clamp to the full store
		write_reg(0, 32'h0000_00ff);
		write_reg(1, 32'h0000_007f);
		push_cmd(OP_DRAW, 122, 58, 127, 63, 130, 60, -5, 7, 100, 8'h5a);
		push_read(127, 63);
		push_read(128, 0);
		wait_idle();
		write_reg(0, 128);
		write_reg(1, 64);
		push_read(127, 63);
		push_read(126, 62);
		wait_idle();

		// random phase on a small screen
		write_reg(0, 12);
		write_reg(1, 10);
		for (int i = 0; i < 25; i++) push_random(12, 10);
		wait_idle();
		long_hold_req = 1;
		for (int i = 0; i < 10; i++) push_read($urandom_range(0, 13), $urandom_range(0, 11));
		wait_idle();
		write_reg(0, 7);
		write_reg(1, 5);
		for (int i = 0; i < 20; i++) push_random(7, 5);
		wait_idle();
		bursts_on = 0;
		for (int i = 0; i < 15; i++) push_random(7, 5);
		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("triangle_rasterizer_depth_test_test passed");
		else
			$display("triangle_rasterizer_depth_test_test failed");
		$finish;
	end

endmodule
